// ===== hw/rtl/b2da_pkg.sv =====
// Shared constants, types and helpers for the binary to decimal ASCII converter.
`timescale 1ns / 1ps

package b2da_pkg;

    // ASCII codes are carried in six bits; the digits sit at 0x30..0x39
    localparam int CHAR_BITS = 6;
    localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;
    localparam logic [CHAR_BITS-1:0] ASCII_NINE = 6'd57;

    // BCD digit width and the add-3 correction threshold of shift-and-add-3
    localparam int BCD_BITS = 4;
    localparam logic [BCD_BITS-1:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [BCD_BITS-1:0] BCD_ADJ_ADD = 4'd3;

    // Depth of the queue between the converter and the emitter
    localparam int QUEUE_DEPTH = 2;

    // Decimal digits needed for a bits-wide unsigned value: floor(bits*log10(2)) + 1
    function automatic int digit_count(input int bits);
        return ((bits * 1233) >> 12) + 1;
    endfunction

    // Front end: idle, shifting bits through the BCD register, handing off the result
    typedef enum logic [1:0] {
        FS_IDLE,
        FS_CONV,
        FS_PUSH
    } front_state_t;

    // Back end: waiting for a converted number, walking its digits out
    typedef enum logic {
        BS_LOAD,
        BS_RUN
    } back_state_t;

endpackage

// ===== hw/rtl/b2da_in_if.sv =====
// Input channel: one unsigned binary number per beat.
`timescale 1ns / 1ps

interface b2da_in_if #(
    parameter int VALUE_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ===== hw/rtl/b2da_out_if.sv =====
// Output channel: one ASCII decimal digit per beat, flagged on the final digit.
`timescale 1ns / 1ps

interface b2da_out_if ();
    import b2da_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// ===== hw/rtl/binary_to_decimal_ascii_core.sv =====
// Top level of the binary to decimal ASCII converter.
`timescale 1ns / 1ps
//
//  channel  | dir | payload                         | beat
//  ---------+-----+---------------------------------+------------------------------
//  in_ch    | in  | value[VALUE_BITS-1:0]           | one number to convert
//  out_ch   | out | digit_char[5:0], last_digit     | one ASCII digit, MSD first
//
//  The converter handles each number in turn: accept, one shift-and-add-3 step per
//  input bit, hand-off; it takes no new number until the hand-off is done.
//  The emitter loads a number, skips each leading zero and sends each digit that
//  follows, MSD first; a two-entry queue between them lets the converter run ahead.
//  Reset clears all control state; no clearing pass, the block is ready at once.
//  A stalled output only holds the emitter; the converter keeps working until full.

module binary_to_decimal_ascii_core #(
    parameter int VALUE_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    b2da_in_if.sink    in_ch,
    b2da_out_if.source out_ch
);
    import b2da_pkg::*;

    localparam int DW = digit_count(VALUE_BITS) * BCD_BITS;

    logic          push_valid;
    logic          push_ready;
    logic [DW-1:0] push_data;
    logic          pop_valid;
    logic          pop_ready;
    logic [DW-1:0] pop_data;

    // Binary to BCD conversion
    b2da_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Hand-off queue
    b2da_queue #(
        .WIDTH (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Digit emitter
    b2da_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_ch    (out_ch)
    );
endmodule

// ===== hw/rtl/b2da_front.sv =====
// Front end: accepts a number and converts it to packed BCD by shift-and-add-3.
`timescale 1ns / 1ps

module b2da_front #(
    parameter int VALUE_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    b2da_in_if.sink in_ch,
    output logic push_valid,
    input  logic push_ready,
    output logic [b2da_pkg::digit_count(VALUE_BITS)*b2da_pkg::BCD_BITS-1:0] push_data
);
    import b2da_pkg::*;

    localparam int DIGITS = digit_count(VALUE_BITS);
    localparam int DW     = DIGITS * BCD_BITS;
    localparam int CW     = $clog2(VALUE_BITS + 1);

    front_state_t          state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [DW-1:0]         bcd_reg, bcd_next;
    logic [DW-1:0]         bcd_adj;
    logic                  accept;
    logic                  conv_done;

    assign accept    = in_ch.valid && in_ch.ready;
    assign conv_done = (cnt_reg == CW'(1));

    // Add 3 to every digit of 5 or more ahead of the shift
    always_comb
    begin : adjust
        logic [BCD_BITS-1:0] d;
        d = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            d = bcd_reg[i*BCD_BITS +: BCD_BITS];
            bcd_adj[i*BCD_BITS +: BCD_BITS] = (d >= BCD_ADJ_MIN) ? d + BCD_ADJ_ADD : d;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FS_IDLE:
            begin
                if (accept)
                    state_next = FS_CONV;
            end
            FS_CONV:
            begin
                if (conv_done)
                    state_next = FS_PUSH;
            end
            FS_PUSH:
            begin
                if (push_ready)
                    state_next = FS_IDLE;
            end
            default: state_next = FS_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        in_ch.ready = 1'b0;
        push_valid  = 1'b0;
        cnt_next    = cnt_reg;
        bin_next    = bin_reg;
        bcd_next    = bcd_reg;
        case (state_reg)
            FS_IDLE:
            begin
                in_ch.ready = 1'b1;
                cnt_next    = CW'(VALUE_BITS);
                bin_next    = in_ch.value;
                bcd_next    = '0;
            end
            FS_CONV:
            begin
                cnt_next = cnt_reg - 1'b1;
                bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
                bcd_next = {bcd_adj[DW-2:0], bin_reg[VALUE_BITS-1]};
            end
            FS_PUSH:
            begin
                push_valid = 1'b1;
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    assign push_data = bcd_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    // Bit counter must never run out while shifting
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FS_CONV) |-> (cnt_reg != '0))
        else $error("front: shift counter empty during conversion");

    // Conversion ends exactly after the last shift
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FS_CONV && conv_done) |=> (state_reg == FS_PUSH))
        else $error("front: conversion did not hand off");
endmodule

// ===== hw/rtl/b2da_queue.sv =====
// Small register queue decoupling the converter from the digit emitter.
`timescale 1ns / 1ps

module b2da_queue #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Fill count stays within the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue: fill count beyond depth");

    // Pointers agree with the count when empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue: pointers out of step with count");
endmodule

// ===== hw/rtl/b2da_back.sv =====
// Back end: walks a BCD number from the top, drops leading zeros, emits ASCII digits.
`timescale 1ns / 1ps

module b2da_back #(
    parameter int VALUE_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic pop_valid,
    output logic pop_ready,
    input  logic [b2da_pkg::digit_count(VALUE_BITS)*b2da_pkg::BCD_BITS-1:0] pop_data,
    b2da_out_if.source out_ch
);
    import b2da_pkg::*;

    localparam int DIGITS = digit_count(VALUE_BITS);
    localparam int DW     = DIGITS * BCD_BITS;
    localparam int IW     = $clog2(DIGITS);

    back_state_t          state_reg, state_next;
    logic [DW-1:0]        bcd_reg, bcd_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic                 lead_reg, lead_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_BITS-1:0] digit_char_reg, digit_char_next;
    logic                 last_digit_reg, last_digit_next;
    logic [BCD_BITS-1:0]  cur_digit;
    logic                 is_last;
    logic                 out_free;
    logic                 skip;
    logic                 emit;

    assign cur_digit = bcd_reg[idx_reg*BCD_BITS +: BCD_BITS];
    assign is_last   = (idx_reg == '0);
    assign out_free  = !out_valid_reg || out_ch.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BS_LOAD:
            begin
                if (pop_valid)
                    state_next = BS_RUN;
            end
            BS_RUN:
            begin
                if (emit && is_last)
                    state_next = BS_LOAD;
            end
            default: state_next = BS_LOAD;
        endcase
    end

    // Outputs and digit walk
    always_comb
    begin
        pop_ready       = 1'b0;
        skip            = 1'b0;
        emit            = 1'b0;
        bcd_next        = bcd_reg;
        idx_next        = idx_reg;
        lead_next       = lead_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        digit_char_next = digit_char_reg;
        last_digit_next = last_digit_reg;
        case (state_reg)
            BS_LOAD:
            begin
                pop_ready = 1'b1;
                bcd_next  = pop_data;
                idx_next  = IW'(DIGITS - 1);
                lead_next = 1'b1;
            end
            BS_RUN:
            begin
                // Leading zero, but never the units digit
                skip = lead_reg && (cur_digit == '0) && !is_last;
                emit = !skip && out_free;
                if (skip || emit)
                    idx_next = idx_reg - 1'b1;
                if (emit)
                begin
                    lead_next       = 1'b0;
                    out_valid_next  = 1'b1;
                    digit_char_next = ASCII_ZERO + CHAR_BITS'(cur_digit);
                    last_digit_next = is_last;
                end
            end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.digit_char = digit_char_reg;
    assign out_ch.last_digit = last_digit_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_LOAD;
            out_valid_reg <= 1'b0;
            lead_reg      <= 1'b1;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            lead_reg      <= lead_next;
            idx_reg       <= idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bcd_reg        <= bcd_next;
        digit_char_reg <= digit_char_next;
        last_digit_reg <= last_digit_next;
    end

    // Every emitted character is a decimal digit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (digit_char_reg >= ASCII_ZERO && digit_char_reg <= ASCII_NINE))
        else $error("back: emitted character is not a decimal digit");

    // A run never opens with a zero unless it is the lone digit
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && lead_reg && !is_last) |-> (cur_digit != '0))
        else $error("back: leading zero emitted");
endmodule
